// ===== rtl/pgu_pkg.sv =====
// shared types and constants for the permutation generator
package pgu_pkg;

    localparam int MAX_SET_SIZE_DEF = 8;
    localparam int DIGIT_W          = 4;
    localparam int SET_SIZE_W       = 4;
    localparam int PERM_W           = 32;
    localparam int WORD_DIGITS      = PERM_W / DIGIT_W;
    localparam logic [SET_SIZE_W-1:0] SET_SIZE_RESET = 4'd3;

    // register map, by word index
    localparam logic REG_SET_SIZE = 1'b0;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_UP,
        CELL_FROM_DOWN
    } cell_op_t;

    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_PUSH,
        ROW_POP,
        ROW_SET
    } row_op_t;

    typedef struct packed {
        row_op_t              op;
        logic [DIGIT_W-1:0]   digit;
    } row_ctrl_t;

endpackage

// ===== rtl/pgu_cell.sv =====
// one stack cell: holds a digit, takes it from the neighbor above or below
module pgu_cell (
    input  logic                         aclk,
    input  pgu_pkg::cell_op_t            op,
    input  logic [pgu_pkg::DIGIT_W-1:0]  up_digit,
    input  logic [pgu_pkg::DIGIT_W-1:0]  down_digit,
    output logic [pgu_pkg::DIGIT_W-1:0]  digit
);

    logic [pgu_pkg::DIGIT_W-1:0] digit_reg;
    logic [pgu_pkg::DIGIT_W-1:0] digit_next;

    always_comb begin
        case (op)
            pgu_pkg::CELL_FROM_UP:   digit_next = up_digit;
            pgu_pkg::CELL_FROM_DOWN: digit_next = down_digit;
            default:                 digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

// ===== rtl/pgu_row.sv =====
// row of stack cells, top of stack in cell 0
module pgu_row #(
    parameter int MAX_SET_SIZE = pgu_pkg::MAX_SET_SIZE_DEF
) (
    input  logic                                           aclk,
    input  pgu_pkg::row_ctrl_t                             ctrl,
    output logic [MAX_SET_SIZE-1:0][pgu_pkg::DIGIT_W-1:0]  cells
);

    genvar i;
    generate
        for (i = 0; i < MAX_SET_SIZE; i++) begin : g_cell
            logic [pgu_pkg::DIGIT_W-1:0] up_digit;
            logic [pgu_pkg::DIGIT_W-1:0] down_digit;
            pgu_pkg::cell_op_t           op;

            if (i == 0) begin : g_top
                assign up_digit = ctrl.digit;
            end else begin : g_mid
                assign up_digit = cells[i-1];
            end

            if (i == MAX_SET_SIZE - 1) begin : g_bottom
                assign down_digit = '0;
            end else begin : g_inner
                assign down_digit = cells[i+1];
            end

            always_comb begin
                case (ctrl.op)
                    pgu_pkg::ROW_PUSH: op = pgu_pkg::CELL_FROM_UP;
                    pgu_pkg::ROW_POP:  op = pgu_pkg::CELL_FROM_DOWN;
                    pgu_pkg::ROW_SET:  op = (i == 0) ? pgu_pkg::CELL_FROM_UP
                                                     : pgu_pkg::CELL_HOLD;
                    default:           op = pgu_pkg::CELL_HOLD;
                endcase
            end

            pgu_cell u_cell (
                .aclk       (aclk),
                .op         (op),
                .up_digit   (up_digit),
                .down_digit (down_digit),
                .digit      (cells[i])
            );
        end
    endgenerate

endmodule

// ===== rtl/permutation_generator_unit.sv =====
// Lexicographic permutation source of 1..n, one permutation per request. The current
// permutation lives in a stack of digit cells that shift as one row on push and pop; a
// free-digit mask keeps the digits distinct. A request runs the backtracking search one
// stack level per cycle: pop levels until the top can advance, advance it, then refill
// with the smallest free digits. A restart or first request steps through accept, the fill
// pushes, a check that sees the stack full and the load of the result; a next request first
// pops the exhausted levels, advances the top and then refills the popped levels the same
// way. A result held by a stalled output delays the load. The next request is taken once
// the current result is in the output register.
module permutation_generator_unit #(
    parameter int MAX_SET_SIZE = pgu_pkg::MAX_SET_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] perm_word
    output logic [0:0]  m_tuser,   // [0] is_last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(MAX_SET_SIZE + 1);
    localparam int DW    = pgu_pkg::DIGIT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                depth_reg, depth_next;
    logic [MAX_SET_SIZE:1]           free_reg, free_next;
    logic                            running_reg, running_next;
    logic [pgu_pkg::SET_SIZE_W-1:0]  set_size_reg, set_size_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [pgu_pkg::PERM_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                            m_tuser_reg, m_tuser_next;

    logic [MAX_SET_SIZE-1:0][DW-1:0] cells;
    pgu_pkg::row_ctrl_t              row_ctrl;
    logic [CNT_W-1:0]                n_eff;
    logic [MAX_SET_SIZE:1]           all_free;
    logic [MAX_SET_SIZE:1]           top_bit;
    logic [MAX_SET_SIZE:1]           pick_bit;
    logic [DW-1:0]                   thr;
    logic [DW-1:0]                   pick;
    logic                            found;
    logic                            cfg_wr;
    logic [pgu_pkg::PERM_W-1:0]      word;
    logic                            last;

    // effective set size: zero counts as one, large values saturate
    always_comb begin
        if (set_size_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (int'(set_size_reg) > MAX_SET_SIZE) begin
            n_eff = CNT_W'(MAX_SET_SIZE);
        end else begin
            n_eff = CNT_W'(set_size_reg);
        end
    end

    // smallest free digit above the threshold
    assign thr = (state_reg == ST_ADV) ? cells[0] : '0;

    always_comb begin
        found    = 1'b0;
        pick     = '0;
        pick_bit = '0;
        all_free = '0;
        top_bit  = '0;
        for (int c = MAX_SET_SIZE; c >= 1; c--) begin
            all_free[c] = (c <= int'(n_eff));
            top_bit[c]  = (int'(cells[0]) == c);
            if (free_reg[c] && c > int'(thr)) begin
                found = 1'b1;
                pick  = DW'(c);
            end
        end
        for (int c = 1; c <= MAX_SET_SIZE; c++) begin
            pick_bit[c] = (int'(pick) == c);
        end
    end

    // result view: position p sits in cell n-1-p once the stack is full
    always_comb begin
        word = '0;
        last = 1'b1;
        for (int p = 0; p < pgu_pkg::WORD_DIGITS; p++) begin
            for (int k = 0; k < MAX_SET_SIZE; k++) begin
                if (k + p + 1 == int'(n_eff)) begin
                    word[p*DW +: DW] = cells[k];
                end
            end
        end
        for (int k = 0; k < MAX_SET_SIZE - 1; k++) begin
            if (k + 1 < int'(n_eff) && cells[k] > cells[k+1]) begin
                last = 1'b0;
            end
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        free_next      = free_reg;
        running_next   = running_reg;
        set_size_next  = set_size_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        row_ctrl.op    = pgu_pkg::ROW_HOLD;
        row_ctrl.digit = pick;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[0] || !running_reg) begin
                        depth_next = '0;
                        free_next  = all_free;
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_ADV;
                    end
                end
            end
            ST_ADV: begin
                if (depth_reg == '0) begin
                    free_next  = all_free;
                    state_next = ST_FILL;
                end else if (found) begin
                    row_ctrl.op = pgu_pkg::ROW_SET;
                    free_next   = (free_reg | top_bit) & ~pick_bit;
                    state_next  = ST_FILL;
                end else begin
                    // top level exhausted: give its digit back and pop
                    row_ctrl.op = pgu_pkg::ROW_POP;
                    free_next   = free_reg | top_bit;
                    depth_next  = depth_reg - CNT_W'(1);
                end
            end
            ST_FILL: begin
                if (depth_reg >= n_eff) begin
                    state_next = ST_DONE;
                end else begin
                    row_ctrl.op = pgu_pkg::ROW_PUSH;
                    free_next   = free_reg & ~pick_bit;
                    depth_next  = depth_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = word;
                    m_tuser_next  = last;
                    running_next  = !last;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr && paddr[2] == pgu_pkg::REG_SET_SIZE) begin
            set_size_next = pwdata[pgu_pkg::SET_SIZE_W-1:0];
            running_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            free_reg     <= '0;
            running_reg  <= 1'b0;
            set_size_reg <= pgu_pkg::SET_SIZE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            free_reg     <= free_next;
            running_reg  <= running_next;
            set_size_reg <= set_size_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    pgu_row #(
        .MAX_SET_SIZE (MAX_SET_SIZE)
    ) u_row (
        .aclk  (aclk),
        .ctrl  (row_ctrl),
        .cells (cells)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == pgu_pkg::REG_SET_SIZE)
                      ? {{(32 - pgu_pkg::SET_SIZE_W){1'b0}}, set_size_reg} : '0;

endmodule

// ===== tb/sv/permutation_checker.sv =====
// checker for the permutation generator: predicts each permutation and compares results
module permutation_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] perm_word
    input  logic [0:0]  m_tuser,   // [0] is_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          open_requests
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_N = pgu_pkg::MAX_SET_SIZE_DEF;
    localparam logic [2:0] SET_SIZE_ADDR = 3'(4 * pgu_pkg::REG_SET_SIZE);

    typedef struct packed {
        logic [pgu_pkg::PERM_W-1:0] perm_word;
        logic                       is_last;
    } perm_result_t;

    logic [pgu_pkg::DIGIT_W-1:0]    perm_digits [MAX_N];
    int                             perm_depth;
    bit                             seq_running;
    logic [pgu_pkg::SET_SIZE_W-1:0] cfg_set_size;
    perm_result_t                   expected_perms [$];
    int                             errors = 0;

    // digits held by the levels below lvl
    function automatic logic [15:0] taken_digits(int lvl);
        logic [15:0] m = '0;
        for (int i = 0; i < lvl && i < MAX_N; i++) m[perm_digits[i]] = 1'b1;
        return m;
    endfunction

    // push the smallest free digits until n levels are filled
    function automatic void refill(int n);
        logic [15:0] m;
        int c;
        while (perm_depth < n && perm_depth < MAX_N) begin
            m = taken_digits(perm_depth);
            c = 1;
            while (c <= n && m[c]) c++;
            perm_digits[perm_depth] = pgu_pkg::DIGIT_W'(c);
            perm_depth++;
        end
    endfunction

    // advance the top level, popping exhausted levels; 0 when no permutation is left
    function automatic bit step_forward(int n);
        logic [15:0] m;
        int lvl;
        while (perm_depth > 0) begin
            lvl = perm_depth - 1;
            m = taken_digits(lvl);
            for (int c = perm_digits[lvl] + 1; c <= n; c++) begin
                if (!m[c]) begin
                    perm_digits[lvl] = pgu_pkg::DIGIT_W'(c);
                    refill(n);
                    return 1'b1;
                end
            end
            perm_depth--;
        end
        return 1'b0;
    endfunction

    function automatic perm_result_t next_permutation(logic restart);
        int n;
        perm_result_t r;
        n = (cfg_set_size == 0) ? 1 : (cfg_set_size > MAX_N) ? MAX_N : int'(cfg_set_size);
        if (restart || !seq_running || perm_depth != n || !step_forward(n)) begin
            perm_depth = 0;
            refill(n);
        end
        seq_running = 1'b1;
        r.perm_word = '0;
        r.is_last = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (i < pgu_pkg::WORD_DIGITS) begin
                r.perm_word[pgu_pkg::DIGIT_W*i +: pgu_pkg::DIGIT_W] = perm_digits[i];
            end
            if (i > 0 && perm_digits[i] > perm_digits[i-1]) r.is_last = 1'b0;
        end
        // descending order ends the sequence
        if (r.is_last) seq_running = 1'b0;
        return r;
    endfunction

    always @(posedge aclk) begin
        perm_result_t want;
        if (!aresetn) begin
            cfg_set_size = pgu_pkg::SET_SIZE_RESET;
            perm_depth = 0;
            seq_running = 1'b0;
            perm_digits = '{default: '0};
            expected_perms.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_perms.size() == 0) begin
                    $error("unexpected result: perm_word %h is_last %0d", m_tdata, m_tuser[0]);
                    errors++;
                end else begin
                    want = expected_perms.pop_front();
                    if (m_tdata !== want.perm_word) begin
                        $error("perm_word: expected %h, actual %h", want.perm_word, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== want.is_last) begin
                        $error("is_last: expected %0d, actual %0d", want.is_last, m_tuser[0]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) expected_perms.push_back(next_permutation(s_tdata[0]));
            if (psel && penable && pready && paddr == SET_SIZE_ADDR) begin
                if (pwrite) begin
                    cfg_set_size = pwdata[pgu_pkg::SET_SIZE_W-1:0];
                    seq_running = 1'b0;
                end else if (prdata !== 32'(cfg_set_size)) begin
                    $error("set_size: expected %h, actual %h", 32'(cfg_set_size), prdata);
                    errors++;
                end
            end
        end
        open_requests <= expected_perms.size();
        fail_count <= errors;
    end

endmodule

// ===== tb/sv/tb_permutation_generator_unit.sv =====
// testbench top for the permutation generator: clock, reset, requests, register writes, verdict
module tb_permutation_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT     = 1000000;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int TAIL_ITEMS    = 150;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [2:0] SET_SIZE_ADDR = 3'(4 * pgu_pkg::REG_SET_SIZE);

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int open_requests;
    int cycle_count   = 0;
    int requests_sent = 0;
    int sizes_written = 0;
    int gap_odds      = 0;
    int stall_odds    = 0;
    int stall_left    = 0;
    bit quiet_tail    = 1'b0;

    permutation_generator_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    permutation_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .open_requests (open_requests)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side backpressure: random bursts with m_tready held low
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!quiet_tail && stall_odds != 0
                     && $urandom_range(stall_odds - 1, 0) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(15, 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic restart);
        if (!quiet_tail && gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, restart};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // wait until every request has its result, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (open_requests != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write set_size, then read it back
    task automatic write_set_size(input logic [pgu_pkg::SET_SIZE_W-1:0] value);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= SET_SIZE_ADDR;
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        sizes_written++;
    endtask

    initial begin
        int remaining;
        int count;
        int pick;
        int n_eff;
        int fact;
        int restart_odds;
        logic [pgu_pkg::SET_SIZE_W-1:0] size_val;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size of three: the whole sequence, then a request after the last
        repeat (7) send_request(1'b0);
        // single element
        write_set_size(4'd1);
        repeat (2) send_request(1'b0);
        // zero acts as one
        write_set_size(4'd0);
        send_request(1'b0);
        // oversize values saturate
        write_set_size(4'd15);
        send_request(1'b0);
        send_request(1'b1);
        write_set_size(4'd9);
        send_request(1'b0);
        write_set_size(4'd8);
        send_request(1'b0);
        write_set_size(4'd2);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        // rewriting the size mid-sequence starts over
        write_set_size(4'd4);
        repeat (3) send_request(1'b0);
        write_set_size(4'd4);
        send_request(1'b0);

        remaining = RANDOM_ITEMS;
        while (remaining > 0) begin
            pick = $urandom_range(19, 0);
            if (pick < 2)
                size_val = ($urandom_range(1, 0) == 0) ? 4'd0 : 4'($urandom_range(15, 9));
            else if (pick < 4)
                size_val = 4'($urandom_range(8, 7));
            else if (pick < 6)
                size_val = 4'd6;
            else
                size_val = 4'($urandom_range(5, 1));
            n_eff = (size_val == 0) ? 1 : (size_val > 8) ? 8 : int'(size_val);
            if (n_eff <= 5) begin
                fact = 1;
                for (int k = 2; k <= n_eff; k++) fact *= k;
                count = fact + $urandom_range(fact, 0);
            end else begin
                count = $urandom_range(120, 20);
            end
            if (count > remaining) count = remaining;

            pick = $urandom_range(2, 0);
            restart_odds = (pick == 0) ? 0 : (pick == 1) ? 32 : 6;
            pick = $urandom_range(2, 0);
            gap_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 10;
            pick = $urandom_range(2, 0);
            stall_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 10;

            write_set_size(size_val);
            for (int k = 0; k < count; k++) begin
                quiet_tail = (remaining - k) <= TAIL_ITEMS;
                send_request(restart_odds != 0 && $urandom_range(restart_odds - 1, 0) == 0);
            end
            remaining -= count;
        end

        wait_drained();
        $display("covered %0d requests over %0d set_size writes, incl. restarts and wraps,",
                 requests_sent, sizes_written);
        $display("with random request gaps and result stalls");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
